/* sv/lcart_pkg.sv */
// Shared definitions for the load cell readout with tare: phase codes,
// microprogram words and ROM, register indexes, result word layout.
// No dependencies.
package lcart_pkg;

    // widths and reset values
    localparam int DATA_BITS_DEF  = 24;
    localparam int RAW_W          = 24;
    localparam int WEIGHT_W       = 25;
    localparam int LIMIT_W        = 20;
    localparam int MARGIN_W       = 16;
    localparam int DIVISOR_W      = 16;
    localparam int CFG_IDX_W      = 2;
    localparam int IN_W           = 8;
    localparam int OUT_W          = 56;

    localparam logic [LIMIT_W-1:0]   LIMIT_RST   = 20'd1000000;
    localparam logic [MARGIN_W-1:0]  MARGIN_RST  = 16'd200;
    localparam logic [DIVISOR_W-1:0] DIVISOR_RST = 16'd4745;

    // divider: |raw - tare| * 10 fits in 28 bits
    localparam int DIVIDEND_W = 28;
    localparam int DIV_CNT_W  = $clog2(DIVIDEND_W);
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIVIDEND_W - 1);

    localparam logic [DIVIDEND_W-1:0] W_POS_LIMIT = 28'd16777215;
    localparam logic [DIVIDEND_W-1:0] W_NEG_LIMIT = 28'd16777216;
    localparam logic signed [WEIGHT_W-1:0] W_MAX  = 25'sh0FFFFFF;
    localparam logic signed [WEIGHT_W-1:0] W_MIN  = 25'sh1000000;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MARGIN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DIVISOR = 2'd2;

    // read sequence phases
    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_WAIT = 3'd1;
    localparam logic [2:0] PH_HIGH = 3'd2;
    localparam logic [2:0] PH_LOW  = 3'd3;
    localparam logic [2:0] PH_GAIN = 3'd4;
    localparam logic [2:0] PH_DONE = 3'd5;

    // input word bit positions
    localparam int IN_START = 0;
    localparam int IN_DOUT  = 1;

    // result word bit positions, lowest first
    localparam int OUT_SCK     = 0;
    localparam int OUT_BUSY    = 1;
    localparam int OUT_DONE    = 2;
    localparam int OUT_RAW     = 3;
    localparam int OUT_WEIGHT  = 27;
    localparam int OUT_WVALID  = 52;
    localparam int OUT_TIMEOUT = 53;
    localparam int OUT_TARE    = 54;

    // micro-ops
    localparam logic [2:0] OP_TICK     = 3'd0;
    localparam logic [2:0] OP_RAW      = 3'd1;
    localparam logic [2:0] OP_DIV_INIT = 3'd2;
    localparam logic [2:0] OP_DIV_STEP = 3'd3;
    localparam logic [2:0] OP_FIX      = 3'd4;
    localparam logic [2:0] OP_EMIT     = 3'd5;
    localparam logic [2:0] OP_NOP      = 3'd6;

    // jump conditions
    localparam logic [2:0] J_NEXT     = 3'd0;
    localparam logic [2:0] J_TICK     = 3'd1;  // taken unless a done tick was accepted
    localparam logic [2:0] J_SKIP     = 3'd2;  // taken when no scaling is needed
    localparam logic [2:0] J_LOOP     = 3'd3;  // taken while divider steps remain
    localparam logic [2:0] J_OUT_BUSY = 3'd4;
    localparam logic [2:0] J_ALWAYS   = 3'd5;

    localparam int UPC_W = 3;
    localparam logic [UPC_W-1:0] U_TICK     = 3'd0;
    localparam logic [UPC_W-1:0] U_RAW      = 3'd1;
    localparam logic [UPC_W-1:0] U_DIV_INIT = 3'd2;
    localparam logic [UPC_W-1:0] U_DIV_STEP = 3'd3;
    localparam logic [UPC_W-1:0] U_FIX      = 3'd4;
    localparam logic [UPC_W-1:0] U_EMIT     = 3'd5;
    localparam logic [UPC_W-1:0] U_RET      = 3'd6;

    typedef struct packed {
        logic [2:0]       op;
        logic [2:0]       jmp;
        logic [UPC_W-1:0] target;
    } ucode_t;

    function automatic ucode_t ucode_rom(input logic [UPC_W-1:0] addr);
        ucode_t w;
        unique case (addr)
            U_TICK:     w = '{op: OP_TICK,     jmp: J_TICK,     target: U_TICK};
            U_RAW:      w = '{op: OP_RAW,      jmp: J_SKIP,     target: U_EMIT};
            U_DIV_INIT: w = '{op: OP_DIV_INIT, jmp: J_NEXT,     target: U_TICK};
            U_DIV_STEP: w = '{op: OP_DIV_STEP, jmp: J_LOOP,     target: U_DIV_STEP};
            U_FIX:      w = '{op: OP_FIX,      jmp: J_NEXT,     target: U_TICK};
            U_EMIT:     w = '{op: OP_EMIT,     jmp: J_OUT_BUSY, target: U_EMIT};
            U_RET:      w = '{op: OP_NOP,      jmp: J_ALWAYS,   target: U_TICK};
            default:    w = '{op: OP_NOP,      jmp: J_ALWAYS,   target: U_TICK};
        endcase
        return w;
    endfunction

    function automatic logic [OUT_W-1:0] pack_out(
        input logic                       sck,
        input logic                       busy,
        input logic                       done,
        input logic [RAW_W-1:0]           raw,
        input logic signed [WEIGHT_W-1:0] weight,
        input logic                       wvalid,
        input logic                       timed_out,
        input logic                       tare_taken
    );
        return {1'b0, tare_taken, timed_out, wvalid, weight, raw, done, busy, sck};
    endfunction

endpackage

/* sv/load_cell_adc_readout_tare.sv */
// Load cell converter readout with tare and scaling, driven by a microprogram.
// Each input request is one tick; each tick gives one result request.
// Ordinary ticks: the result is registered from the accepted request.
// Done tick: RAW, then DIV_INIT, the restoring divider steps and FIX unless the tare
// is taken or the reading is rejected, then EMIT and RET; no request is taken meanwhile.
// rst_n clears all control state and loads the register defaults asynchronously.
module load_cell_adc_readout_tare
    import lcart_pkg::*;
#(
    parameter int DATA_BITS = DATA_BITS_DEF
)(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [LIMIT_W-1:0]   cfg_data,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [IN_W-1:0]      s_tdata,   // start_req, dout, pad
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // sck, busy_res, done_res, raw_value[24], weight[25], weight_valid,
    // timed_out, tare_taken, pad
    output logic [OUT_W-1:0]     m_tdata
);

    localparam int BC_W = $clog2(DATA_BITS + 1);
    localparam logic [DATA_BITS-1:0] MSB_BIT = {1'b1, {(DATA_BITS-1){1'b0}}};

    // configuration
    logic [LIMIT_W-1:0]   timeout_limit_reg;
    logic [MARGIN_W-1:0]  tare_margin_reg;
    logic [DIVISOR_W-1:0] divisor_reg;

    // read sequence state
    logic [2:0]                  phase_reg, phase_next;
    logic [BC_W-1:0]             bit_count_reg, bit_count_next;
    logic [DATA_BITS-1:0]        shift_reg, shift_next;
    logic [LIMIT_W-1:0]          wait_count_reg, wait_count_next;
    logic                        low_seen_reg, low_seen_next;
    logic [RAW_W-1:0]            tare_reg, tare_next;
    logic                        tare_valid_reg, tare_valid_next;
    logic signed [WEIGHT_W-1:0]  weight_hold_reg, weight_hold_next;
    logic                        timeout_flag_reg, timeout_flag_next;

    // sequencer and scaling datapath
    logic [UPC_W-1:0]            upc_reg, upc_next;
    logic [RAW_W-1:0]            raw_reg, raw_next;
    logic signed [WEIGHT_W-1:0]  diff_reg, diff_next;
    logic                        neg_reg, neg_next;
    logic [DIVISOR_W-1:0]        rem_reg, rem_next;
    logic [DIVIDEND_W-1:0]       quo_reg, quo_next;
    logic [DIV_CNT_W-1:0]        cnt_reg, cnt_next;
    logic                        wvalid_reg, wvalid_next;
    logic                        tare_now_reg, tare_now_next;
    logic                        out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]            out_data_reg, out_data_next;

    ucode_t               uc;
    logic                 out_free;
    logic                 in_accept;
    logic                 start_in;
    logic                 dout_in;
    logic                 jump;
    logic [DATA_BITS-1:0] flipped;
    logic [RAW_W-1:0]     raw_calc;
    logic                 in_range;
    logic [RAW_W-1:0]     mag;
    logic [DIVIDEND_W-1:0] dividend;
    logic [DIVISOR_W-1:0] div_eff;
    logic [DIVISOR_W:0]   rem_shift;
    logic [DIVISOR_W:0]   rem_trial;
    logic [BC_W-1:0]      bc_inc;
    logic [LIMIT_W-1:0]   wc_inc;
    logic                 t_sck;
    logic                 t_busy;

    assign uc        = ucode_rom(upc_reg);
    assign out_free  = !out_valid_reg || m_tready;
    assign s_tready  = (uc.op == OP_TICK) && out_free;
    assign in_accept = s_tvalid && s_tready;
    assign start_in  = s_tdata[IN_START];
    assign dout_in   = s_tdata[IN_DOUT];
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    // reading with the top bit inverted, brought to 24 bits
    assign flipped = shift_reg ^ MSB_BIT;
    generate
        if (DATA_BITS >= RAW_W) begin : g_wide
            assign raw_calc = flipped[RAW_W-1:0];
        end else begin : g_narrow
            assign raw_calc = {{(RAW_W-DATA_BITS){1'b0}}, flipped};
        end
    endgenerate

    // raw > tare - margin, kept unsigned
    assign in_range = ({1'b0, raw_calc} + {{(RAW_W+1-MARGIN_W){1'b0}}, tare_margin_reg})
                      > {1'b0, tare_reg};

    assign mag      = diff_reg[WEIGHT_W-1] ? RAW_W'(-diff_reg) : diff_reg[RAW_W-1:0];
    assign dividend = ({4'b0, mag} << 3) + ({4'b0, mag} << 1);
    assign div_eff  = (divisor_reg == '0) ? DIVISOR_W'(1) : divisor_reg;
    assign rem_shift = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign rem_trial = rem_shift - {1'b0, div_eff};

    assign bc_inc = bit_count_reg + 1'b1;
    assign wc_inc = wait_count_reg + 1'b1;

    // jump condition
    always_comb
    begin
        unique case (uc.jmp)
            J_NEXT:     jump = 1'b0;
            J_TICK:     jump = !(in_accept && (phase_reg == PH_DONE));
            J_SKIP:     jump = !tare_valid_reg || !in_range;
            J_LOOP:     jump = (cnt_reg != '0);
            J_OUT_BUSY: jump = !out_free;
            J_ALWAYS:   jump = 1'b1;
            default:    jump = 1'b1;
        endcase
        upc_next = jump ? uc.target : upc_reg + 1'b1;
    end

    always_comb
    begin
        phase_next        = phase_reg;
        bit_count_next    = bit_count_reg;
        shift_next        = shift_reg;
        wait_count_next   = wait_count_reg;
        low_seen_next     = low_seen_reg;
        tare_next         = tare_reg;
        tare_valid_next   = tare_valid_reg;
        weight_hold_next  = weight_hold_reg;
        timeout_flag_next = timeout_flag_reg;
        raw_next          = raw_reg;
        diff_next         = diff_reg;
        neg_next          = neg_reg;
        rem_next          = rem_reg;
        quo_next          = quo_reg;
        cnt_next          = cnt_reg;
        wvalid_next       = wvalid_reg;
        tare_now_next     = tare_now_reg;
        out_valid_next    = out_valid_reg && !m_tready;
        out_data_next     = out_data_reg;
        t_sck             = 1'b0;
        t_busy            = 1'b1;

        unique case (uc.op)
            OP_TICK:
            begin
                if (in_accept && (phase_reg != PH_DONE))
                begin
                    unique case (phase_reg)
                        PH_WAIT:
                        begin
                            if (!dout_in && low_seen_reg)
                                phase_next = PH_HIGH;
                            else
                            begin
                                low_seen_next   = !dout_in;
                                wait_count_next = wc_inc;
                                if (wc_inc >= timeout_limit_reg)
                                begin
                                    timeout_flag_next = 1'b1;
                                    phase_next        = PH_HIGH;
                                end
                            end
                        end
                        PH_HIGH:
                        begin
                            t_sck      = 1'b1;
                            phase_next = PH_LOW;
                        end
                        PH_LOW:
                        begin
                            shift_next     = {shift_reg[DATA_BITS-2:0], dout_in};
                            bit_count_next = bc_inc;
                            phase_next     = (bc_inc >= BC_W'(DATA_BITS)) ? PH_GAIN : PH_HIGH;
                        end
                        PH_GAIN:
                        begin
                            t_sck      = 1'b1;
                            phase_next = PH_DONE;
                        end
                        default:
                        begin
                            // idle and unused codes
                            phase_next = PH_IDLE;
                            t_busy     = start_in;
                            if (start_in)
                            begin
                                phase_next        = PH_WAIT;
                                wait_count_next   = '0;
                                low_seen_next     = 1'b0;
                                timeout_flag_next = 1'b0;
                                bit_count_next    = '0;
                                shift_next        = '0;
                            end
                        end
                    endcase
                    out_valid_next = 1'b1;
                    out_data_next  = pack_out(t_sck, t_busy, 1'b0, '0, weight_hold_reg,
                                              1'b0, timeout_flag_next, 1'b0);
                end
            end
            OP_RAW:
            begin
                raw_next      = raw_calc;
                diff_next     = $signed({1'b0, raw_calc}) - $signed({1'b0, tare_reg});
                wvalid_next   = 1'b0;
                tare_now_next = !tare_valid_reg;
                if (!tare_valid_reg)
                begin
                    tare_next       = raw_calc;
                    tare_valid_next = 1'b1;
                end
            end
            OP_DIV_INIT:
            begin
                neg_next = diff_reg[WEIGHT_W-1];
                quo_next = dividend;
                rem_next = '0;
                cnt_next = DIV_LAST;
            end
            OP_DIV_STEP:
            begin
                if (!rem_trial[DIVISOR_W])
                begin
                    rem_next = rem_trial[DIVISOR_W-1:0];
                    quo_next = {quo_reg[DIVIDEND_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_shift[DIVISOR_W-1:0];
                    quo_next = {quo_reg[DIVIDEND_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg - 1'b1;
            end
            OP_FIX:
            begin
                wvalid_next = 1'b1;
                if (!neg_reg)
                    weight_hold_next = (quo_reg > W_POS_LIMIT) ? W_MAX
                                       : $signed(quo_reg[WEIGHT_W-1:0]);
                else
                    weight_hold_next = (quo_reg > W_NEG_LIMIT) ? W_MIN
                                       : -$signed(quo_reg[WEIGHT_W-1:0]);
            end
            OP_EMIT:
            begin
                if (out_free)
                begin
                    phase_next     = PH_IDLE;
                    out_valid_next = 1'b1;
                    out_data_next  = pack_out(1'b0, 1'b0, 1'b1, raw_reg, weight_hold_reg,
                                              wvalid_reg, timeout_flag_reg, tare_now_reg);
                end
            end
            default:
            begin
                // no datapath action
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_limit_reg <= LIMIT_RST;
            tare_margin_reg   <= MARGIN_RST;
            divisor_reg       <= DIVISOR_RST;
            phase_reg         <= PH_IDLE;
            bit_count_reg     <= '0;
            shift_reg         <= '0;
            wait_count_reg    <= '0;
            low_seen_reg      <= 1'b0;
            tare_reg          <= '0;
            tare_valid_reg    <= 1'b0;
            weight_hold_reg   <= '0;
            timeout_flag_reg  <= 1'b0;
            upc_reg           <= U_TICK;
            cnt_reg           <= '0;
            neg_reg           <= 1'b0;
            wvalid_reg        <= 1'b0;
            tare_now_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_TIMEOUT: timeout_limit_reg <= cfg_data;
                    REG_MARGIN:  tare_margin_reg   <= cfg_data[MARGIN_W-1:0];
                    REG_DIVISOR: divisor_reg       <= cfg_data[DIVISOR_W-1:0];
                    default:
                    begin
                        // unmapped index, write dropped
                    end
                endcase
            end
            phase_reg        <= phase_next;
            bit_count_reg    <= bit_count_next;
            shift_reg        <= shift_next;
            wait_count_reg   <= wait_count_next;
            low_seen_reg     <= low_seen_next;
            tare_reg         <= tare_next;
            tare_valid_reg   <= tare_valid_next;
            weight_hold_reg  <= weight_hold_next;
            timeout_flag_reg <= timeout_flag_next;
            upc_reg          <= upc_next;
            cnt_reg          <= cnt_next;
            neg_reg          <= neg_next;
            wvalid_reg       <= wvalid_next;
            tare_now_reg     <= tare_now_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        raw_reg      <= raw_next;
        diff_reg     <= diff_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        out_data_reg <= out_data_next;
    end

endmodule

/* sv/lcart_checker.sv */
// Port-level checks for the load cell readout, bound to the top level.
// Depends on lcart_pkg for the result word layout.
module lcart_checker
    import lcart_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 cfg_valid,
    input logic                 cfg_ready,
    input logic [CFG_IDX_W-1:0] cfg_index,
    input logic [LIMIT_W-1:0]   cfg_data,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic [IN_W-1:0]      s_tdata,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [OUT_W-1:0]     m_tdata
);

    // stalled result request holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result request changed while stalled");

    // one result per tick: no new request taken while the result is stalled
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken with result stalled");

    // the done tick drives no clock and ends the busy span
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[OUT_DONE] |-> !m_tdata[OUT_BUSY] && !m_tdata[OUT_SCK])
        else $error("done tick with sck or busy");

    // reading, tare and weight flags appear only on the done tick
    a_done_only: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[OUT_DONE] |->
            !m_tdata[OUT_WVALID] && !m_tdata[OUT_TARE] &&
            (m_tdata[OUT_RAW +: RAW_W] == '0))
        else $error("conversion fields outside the done tick");

    // a conversion is either the tare or a weight, never both
    a_tare_xor_weight: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[OUT_TARE] && m_tdata[OUT_WVALID]))
        else $error("tare and weight on the same conversion");

endmodule

bind load_cell_adc_readout_tare lcart_checker u_lcart_checker (.*);
